// ===== rtl/two_body_gravity_euler_step_core_defines.svh =====
// Assertion macros shared by the checker.
`ifndef TWO_BODY_GRAVITY_EULER_STEP_CORE_DEFINES_SVH
`define TWO_BODY_GRAVITY_EULER_STEP_CORE_DEFINES_SVH

// same-cycle implication
`define TBG_ASSERT_SAME(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tbg port check failed");

// next-cycle implication
`define TBG_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tbg port check failed");

`endif

// ===== rtl/tbg_pkg.sv =====
package tbg_pkg;

  localparam int PW   = 48;   // position / velocity / gm width
  localparam int DW   = PW + 1; // difference width
  localparam int SQW  = 98;   // squared distance width
  localparam int LW   = 49;   // root width
  localparam int AW   = 47;   // acceleration magnitude width
  localparam int PRW  = AW + DW; // magnitude times |diff|
  localparam int W    = 104;  // shared unit datapath width
  localparam int CW   = 7;    // iteration counter width
  localparam int GM_SHIFT = 56;

  localparam logic [CW-1:0] ITER_DIV = CW'(W);
  localparam logic [CW-1:0] ITER_MUL = CW'(W / 2);

  localparam logic [PW-1:0] GM2_RESET = PW'(398137754);
  localparam logic [PW-1:0] GM1_RESET = PW'(4375183);

  typedef enum logic {
    CFG_GM_SECOND = 1'b0,
    CFG_GM_FIRST  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_cmd_t;

  typedef struct packed {
    logic                 kind;
    logic                 body_select;
    logic signed [PW-1:0] load_pos_x;
    logic signed [PW-1:0] load_pos_y;
    logic signed [PW-1:0] load_vel_x;
    logic signed [PW-1:0] load_vel_y;
  } tbg_in_t;

  typedef struct packed {
    logic signed [PW-1:0] first_x;
    logic signed [PW-1:0] first_y;
    logic signed [PW-1:0] second_x;
    logic signed [PW-1:0] second_y;
    logic                 coincident;
  } tbg_out_t;

endpackage

// ===== rtl/tbg_alu.sv =====
// Shared iterative unit: shift-add multiply, restoring divide, digit-by-digit root.
module tbg_alu (
  input  logic                       clk,
  input  logic                       rst,
  input  tbg_pkg::alu_cmd_t          cmd,
  input  logic [tbg_pkg::W-1:0]      opa,
  input  logic [tbg_pkg::W-1:0]      opb,
  output logic                       done,
  output logic [tbg_pkg::W-1:0]      result
);

  localparam int W = tbg_pkg::W;

  logic                      busy;
  tbg_pkg::alu_op_t          op_q;
  logic [tbg_pkg::CW-1:0]    cnt;
  logic [W-1:0]              r, n, d, q;
  logic [W-1:0]              x, y;
  logic                      sub;
  logic [W:0]                sum;
  logic                      take;

  always_comb begin
    unique case (op_q)
      tbg_pkg::OP_DIV: begin
        x   = {r[W-2:0], n[W-1]};
        y   = d;
        sub = 1'b1;
      end
      tbg_pkg::OP_SQRT: begin
        x   = {r[W-3:0], n[W-1:W-2]};
        y   = {q[W-3:0], 2'b01};
        sub = 1'b1;
      end
      default: begin
        x   = r;
        y   = q[0] ? d : '0;
        sub = 1'b0;
      end
    endcase
    // carry out of x + ~y + 1 means x >= y
    sum  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{W{1'b0}}, sub};
    take = sum[W];
  end

  assign result = (op_q == tbg_pkg::OP_MUL) ? r : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == tbg_pkg::CW'(1));
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (cnt == tbg_pkg::CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q <= cmd.op;
      cnt  <= (cmd.op == tbg_pkg::OP_DIV) ? tbg_pkg::ITER_DIV : tbg_pkg::ITER_MUL;
      r    <= '0;
      q    <= (cmd.op == tbg_pkg::OP_MUL) ? opb : '0;
      d    <= (cmd.op == tbg_pkg::OP_MUL) ? opa : opb;
      n    <= opa;
    end else if (busy) begin
      cnt <= cnt - tbg_pkg::CW'(1);
      unique case (op_q)
        tbg_pkg::OP_DIV: begin
          r <= take ? sum[W-1:0] : x;
          q <= {q[W-2:0], take};
          n <= {n[W-2:0], 1'b0};
        end
        tbg_pkg::OP_SQRT: begin
          r <= take ? sum[W-1:0] : x;
          q <= {q[W-2:0], take};
          n <= {n[W-3:0], 2'b00};
        end
        default: begin
          r <= sum[W-1:0];
          d <= {d[W-2:0], 1'b0};
          q <= {1'b0, q[W-1:1]};
        end
      endcase
    end
  end

endmodule

// ===== rtl/two_body_gravity_euler_step_core.sv =====
// channel | dir | handshake         | word
// cfg     | in  | cfg_we            | cfg_index, cfg_data (gm registers)
// in      | in  | in_valid/in_stall | tbg_in_t
// out     | out | out_valid/out_stall | tbg_out_t
//
// Load word: result valid the cycle after accept. Step word: its run time is set by the one
// 104-bit add/subtract unit retiring one bit per cycle, shared by every product, divide and root.
// One word in flight; in_stall is high from accept until the result is taken.
// rst is synchronous: gm registers return to defaults, bodies clear to zero.
// A stalled result holds; the core waits on out_stall with no loss.
module two_body_gravity_euler_step_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [tbg_pkg::PW-1:0]     cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  tbg_pkg::tbg_in_t           in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output tbg_pkg::tbg_out_t          out_word
);

  localparam int PW = tbg_pkg::PW;
  localparam int DW = tbg_pkg::DW;
  localparam int W  = tbg_pkg::W;
  localparam int AW = tbg_pkg::AW;

  typedef enum logic [11:0] {
    ST_IDLE    = 12'b000000000001,
    ST_DIFF    = 12'b000000000010,
    ST_SQ_X    = 12'b000000000100,
    ST_SQ_Y    = 12'b000000001000,
    ST_ROOT    = 12'b000000010000,
    ST_ACC1    = 12'b000000100000,
    ST_ACC2    = 12'b000001000000,
    ST_CMP_MUL = 12'b000010000000,
    ST_CMP_DIV = 12'b000100000000,
    ST_UPD_VEL = 12'b001000000000,
    ST_UPD_POS = 12'b010000000000,
    ST_OUT     = 12'b100000000000
  } state_t;

  state_t state;

  logic [PW-1:0]             gm2, gm1;
  logic signed [PW-1:0]      pos_x [2];
  logic signed [PW-1:0]      pos_y [2];
  logic signed [PW-1:0]      vel_x [2];
  logic signed [PW-1:0]      vel_y [2];

  logic                      bi, ax, co, pend;
  logic signed [DW-1:0]      dx, dy;
  logic [tbg_pkg::SQW-1:0]   d2;
  logic [tbg_pkg::LW-1:0]    len;
  logic [AW-1:0]             a1, a2;
  logic [tbg_pkg::PRW-1:0]   prod;
  logic signed [PW-1:0]      comp_x, comp_y;

  tbg_pkg::alu_cmd_t         cmd;
  logic [W-1:0]              opa, opb, res;
  logic                      alu_done;

  logic [DW-1:0]             mag_x, mag_y, mag_sel;
  logic signed [PW-1:0]      own_px, own_py, oth_px, oth_py, own_vx, own_vy;
  logic signed [PW-1:0]      comp_val, vx_new, vy_new, px_new, py_new;
  logic [AW-1:0]             acc_sat;

  function automatic logic signed [PW-1:0] sat48(input logic signed [PW:0] v);
    if (v[PW] != v[PW-1]) begin
      sat48 = v[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      sat48 = v[PW-1:0];
    end
  endfunction

  always_comb begin
    own_px  = bi ? pos_x[1] : pos_x[0];
    own_py  = bi ? pos_y[1] : pos_y[0];
    oth_px  = bi ? pos_x[0] : pos_x[1];
    oth_py  = bi ? pos_y[0] : pos_y[1];
    own_vx  = bi ? vel_x[1] : vel_x[0];
    own_vy  = bi ? vel_y[1] : vel_y[0];
    mag_x   = dx[DW-1] ? DW'(-dx) : DW'(dx);
    mag_y   = dy[DW-1] ? DW'(-dy) : DW'(dy);
    mag_sel = ax ? mag_y : mag_x;
    // quotient fits below 2^47 on component divides, sign from direction
    comp_val = (ax ? dy[DW-1] : dx[DW-1]) ? -$signed({1'b0, res[AW-1:0]})
                                          : $signed({1'b0, res[AW-1:0]});
    acc_sat = (|res[W-1:AW]) ? {AW{1'b1}} : res[AW-1:0];
    vx_new  = sat48({own_vx[PW-1], own_vx} + {comp_x[PW-1], comp_x});
    vy_new  = sat48({own_vy[PW-1], own_vy} + {comp_y[PW-1], comp_y});
    px_new  = sat48({own_px[PW-1], own_px} + {own_vx[PW-1], own_vx});
    py_new  = sat48({own_py[PW-1], own_py} + {own_vy[PW-1], own_vy});
  end

  // operand routing to the shared unit
  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = tbg_pkg::OP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state)
      ST_SQ_X: begin
        cmd.start = !pend;
        opa = W'(mag_x);
        opb = W'(mag_x);
      end
      ST_SQ_Y: begin
        cmd.start = !pend;
        opa = W'(mag_y);
        opb = W'(mag_y);
      end
      ST_ROOT: begin
        cmd.start = !pend;
        cmd.op    = tbg_pkg::OP_SQRT;
        opa = W'(d2);
      end
      ST_ACC1: begin
        cmd.start = !pend;
        cmd.op    = tbg_pkg::OP_DIV;
        opa = {gm2, {tbg_pkg::GM_SHIFT{1'b0}}};
        opb = W'(d2);
      end
      ST_ACC2: begin
        cmd.start = !pend;
        cmd.op    = tbg_pkg::OP_DIV;
        opa = {gm1, {tbg_pkg::GM_SHIFT{1'b0}}};
        opb = W'(d2);
      end
      ST_CMP_MUL: begin
        cmd.start = !pend && (len != '0);
        opa = W'(bi ? a2 : a1);
        opb = W'(mag_sel);
      end
      ST_CMP_DIV: begin
        cmd.start = !pend;
        cmd.op    = tbg_pkg::OP_DIV;
        opa = W'(prod);
        opb = W'(len);
      end
      default: begin
        cmd.start = 1'b0;
      end
    endcase
  end

  tbg_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .opa    (opa),
    .opb    (opb),
    .done   (alu_done),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
      gm2   <= tbg_pkg::GM2_RESET;
      gm1   <= tbg_pkg::GM1_RESET;
      for (int i = 0; i < 2; i++) begin
        pos_x[i] <= '0;
        pos_y[i] <= '0;
        vel_x[i] <= '0;
        vel_y[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (tbg_pkg::cfg_idx_t'(cfg_index))
          tbg_pkg::CFG_GM_SECOND: gm2 <= cfg_data;
          tbg_pkg::CFG_GM_FIRST:  gm1 <= cfg_data;
          default:                gm2 <= gm2;
        endcase
      end

      if (cmd.start) begin
        pend <= 1'b1;
      end else if (alu_done) begin
        pend <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            co <= 1'b0;
            if (in_word.kind == tbg_pkg::KIND_STEP) begin
              bi    <= 1'b0;
              state <= ST_DIFF;
            end else begin
              pos_x[in_word.body_select] <= in_word.load_pos_x;
              pos_y[in_word.body_select] <= in_word.load_pos_y;
              vel_x[in_word.body_select] <= in_word.load_vel_x;
              vel_y[in_word.body_select] <= in_word.load_vel_y;
              state <= ST_OUT;
            end
          end
        end
        ST_DIFF: begin
          dx    <= {oth_px[PW-1], oth_px} - {own_px[PW-1], own_px};
          dy    <= {oth_py[PW-1], oth_py} - {own_py[PW-1], own_py};
          state <= ST_SQ_X;
        end
        ST_SQ_X: begin
          if (alu_done) begin
            d2    <= res[tbg_pkg::SQW-1:0];
            state <= ST_SQ_Y;
          end
        end
        ST_SQ_Y: begin
          if (alu_done) begin
            d2    <= d2 + res[tbg_pkg::SQW-1:0];
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (alu_done) begin
            len <= res[tbg_pkg::LW-1:0];
            ax  <= 1'b0;
            if (res[tbg_pkg::LW-1:0] == '0) begin
              co <= 1'b1;
              // coincident old positions: both pulls vanish
              if (!bi) begin
                a1 <= '0;
                a2 <= '0;
              end
              state <= ST_CMP_MUL;
            end else begin
              state <= bi ? ST_CMP_MUL : ST_ACC1;
            end
          end
        end
        ST_ACC1: begin
          if (alu_done) begin
            a1    <= acc_sat;
            state <= ST_ACC2;
          end
        end
        ST_ACC2: begin
          if (alu_done) begin
            a2    <= acc_sat;
            state <= ST_CMP_MUL;
          end
        end
        ST_CMP_MUL: begin
          if (len == '0) begin
            if (ax) begin
              comp_y <= '0;
              state  <= ST_UPD_VEL;
            end else begin
              comp_x <= '0;
              ax     <= 1'b1;
            end
          end else if (alu_done) begin
            prod  <= res[tbg_pkg::PRW-1:0];
            state <= ST_CMP_DIV;
          end
        end
        ST_CMP_DIV: begin
          if (alu_done) begin
            if (ax) begin
              comp_y <= comp_val;
              state  <= ST_UPD_VEL;
            end else begin
              comp_x <= comp_val;
              ax     <= 1'b1;
              state  <= ST_CMP_MUL;
            end
          end
        end
        ST_UPD_VEL: begin
          vel_x[bi] <= vx_new;
          vel_y[bi] <= vy_new;
          state     <= ST_UPD_POS;
        end
        ST_UPD_POS: begin
          pos_x[bi] <= px_new;
          pos_y[bi] <= py_new;
          if (bi) begin
            state <= ST_OUT;
          end else begin
            bi    <= 1'b1;
            state <= ST_DIFF;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    out_word.first_x    = pos_x[0];
    out_word.first_y    = pos_y[0];
    out_word.second_x   = pos_x[1];
    out_word.second_y   = pos_y[1];
    out_word.coincident = co;
  end

endmodule

// ===== rtl/tbg_port_check.sv =====
`include "two_body_gravity_euler_step_core_defines.svh"

module tbg_port_check (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tbg_pkg::tbg_out_t out_word
);

  // a waiting result holds still
  `TBG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_word))
  // one word at a time: an accepted word closes the input
  `TBG_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // no new word while a result waits
  `TBG_ASSERT_SAME(a_no_accept_on_out, clk, rst, out_valid, in_stall)
  // a taken result is not shown again
  `TBG_ASSERT_NEXT(a_single_result, clk, rst, out_valid && !out_stall, !out_valid)

endmodule

bind two_body_gravity_euler_step_core tbg_port_check u_port_check (.*);
